@@ hw/rtl/gmd_pkg.sv @@
// Package for the grid maze depth-first search core.
// Field widths, cell and mode codes, register indexes and the sequencer states.
// No dependencies.
package gmd_pkg;

  localparam int GRID_ROWS_DEF   = 16;
  localparam int GRID_COLS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 1024;

  localparam int MODE_W    = 2;
  localparam int COORD_W   = 4;
  localparam int KIND_W    = 2;
  localparam int POP_W     = 12;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [POP_W-1:0] POP_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    CELL_OPEN = 2'd0,
    CELL_WALL = 2'd1,
    CELL_GOAL = 2'd2,
    CELL_SEEN = 2'd3
  } cell_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ROW = 1'd0,
    REG_START_COL = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_POP,
    S_FETCH,
    S_CHECK,
    S_PUSH
  } state_t;

endpackage

@@ hw/rtl/gmd_cmd_if.sv @@
// Command channel of the maze search core: valid/ready plus one input item.
// Depends on gmd_pkg.
interface gmd_cmd_if import gmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [KIND_W-1:0]  cell_kind;

  modport source (output valid, mode, row, col, cell_kind, input ready);
  modport sink   (input valid, mode, row, col, cell_kind, output ready);
endinterface

@@ hw/rtl/gmd_res_if.sv @@
// Result channel of the maze search core: valid/ready plus one result item.
// Depends on gmd_pkg.
interface gmd_res_if import gmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [POP_W-1:0]  pop_count;
  logic              overflow;
  logic [KIND_W-1:0] cell_state;

  modport source (output valid, found, pop_count, overflow, cell_state, input ready);
  modport sink   (input valid, found, pop_count, overflow, cell_state, output ready);
endinterface

@@ hw/rtl/gmd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/grid_maze_dfs_search_core.sv @@
// Grid maze depth-first search core with an explicit position stack.
// After reset the core clears the grid memory, one cell a cycle, and takes no
// item meanwhile. A cell write, an unused mode or an off-grid search is
// answered straight from the idle state; a cell read passes a wait state for
// the registered grid memory read. A search pushes the start cell, then for
// each popped position reads the stack, reads the grid and checks the cell;
// an open cell is marked seen and its on-grid neighbours are pushed one per
// cycle through the single stack write port. The search ends on a goal cell,
// on a stack overflow or when the stack runs empty. Grid and stack are
// synchronous RAMs; the sequencer never overlaps a write and a read of the
// same entry. Depends on gmd_pkg, gmd_cmd_if, gmd_res_if and gmd_ram.
module grid_maze_dfs_search_core import gmd_pkg::*; #(
  parameter int GRID_ROWS   = GRID_ROWS_DEF,
  parameter int GRID_COLS   = GRID_COLS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  gmd_cmd_if.sink              cmd,
  gmd_res_if.source            res
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int GAW   = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int PW    = RW + CW;
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int LVW   = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [COORD_W-1:0] start_row, start_col;
  logic [GAW-1:0]     clr_addr, clr_addr_next;
  logic [LVW-1:0]     level, level_next;
  logic [POP_W-1:0]   pops, pops_next;
  logic [RW-1:0]      cur_r, cur_r_next;
  logic [CW-1:0]      cur_c, cur_c_next;
  logic [1:0]         nb, nb_next;
  logic               rd_on_grid;

  logic               res_valid, res_valid_next;
  logic               res_found, res_found_next;
  logic [POP_W-1:0]   res_pops, res_pops_next;
  logic               res_ovf, res_ovf_next;
  logic [KIND_W-1:0]  res_state, res_state_next;

  logic               g_we;
  logic [GAW-1:0]     g_waddr, g_raddr;
  logic [KIND_W-1:0]  g_wdata, g_rdata;
  logic               s_we;
  logic [SAW-1:0]     s_waddr, s_raddr;
  logic [PW-1:0]      s_wdata, s_rdata;

  logic               accept;
  logic               cmd_on_grid, start_on_grid;
  logic [GAW-1:0]     cmd_addr;
  logic [31:0]        start_r32, start_c32;
  logic [LVW-1:0]     level_m1;
  logic               stack_full;
  logic [RW:0]        nb_r;
  logic [CW:0]        nb_c;
  logic               nb_ok;

  gmd_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  gmd_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign cmd.ready     = (state == S_IDLE) && (!res_valid || res.ready);
  assign accept        = cmd.valid && cmd.ready;
  assign res.valid     = res_valid;
  assign res.found     = res_found;
  assign res.pop_count = res_pops;
  assign res.overflow  = res_ovf;
  assign res.cell_state = res_state;

  assign cmd_on_grid   = (32'(cmd.row) < GRID_ROWS) && (32'(cmd.col) < GRID_COLS);
  assign cmd_addr      = GAW'(32'(cmd.row) * GRID_COLS + 32'(cmd.col));
  assign start_on_grid = (32'(start_row) < GRID_ROWS) && (32'(start_col) < GRID_COLS);
  assign start_r32     = 32'(start_row);
  assign start_c32     = 32'(start_col);
  assign level_m1      = level - 1'b1;
  assign stack_full    = (32'(level) == STACK_DEPTH);

  // neighbour order: down, right, up, left
  always_comb begin
    nb_r  = {1'b0, cur_r};
    nb_c  = {1'b0, cur_c};
    nb_ok = 1'b0;
    case (nb)
      2'd0: begin
        nb_r  = {1'b0, cur_r} + 1'b1;
        nb_ok = 32'(nb_r) < GRID_ROWS;
      end
      2'd1: begin
        nb_c  = {1'b0, cur_c} + 1'b1;
        nb_ok = 32'(nb_c) < GRID_COLS;
      end
      2'd2: begin
        nb_r  = {1'b0, cur_r} - 1'b1;
        nb_ok = (cur_r != '0);
      end
      default: begin
        nb_c  = {1'b0, cur_c} - 1'b1;
        nb_ok = (cur_c != '0);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (32'(clr_addr) == CELLS - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (mode_t'(cmd.mode))
            MODE_SEARCH: if (start_on_grid) state_next = S_POP;
            MODE_READ:   state_next = S_RD_WAIT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT: state_next = S_IDLE;
      S_POP: begin
        state_next = (level == '0) ? S_IDLE : S_FETCH;
      end
      S_FETCH: state_next = S_CHECK;
      S_CHECK: begin
        case (cell_t'(g_rdata))
          CELL_GOAL: state_next = S_IDLE;
          CELL_OPEN: state_next = S_PUSH;
          default:   state_next = S_POP;
        endcase
      end
      S_PUSH: begin
        if (nb_ok && stack_full)  state_next = S_IDLE;
        else if (nb == 2'd3)      state_next = S_POP;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    clr_addr_next  = clr_addr;
    level_next     = level;
    pops_next      = pops;
    cur_r_next     = cur_r;
    cur_c_next     = cur_c;
    nb_next        = nb;
    res_valid_next = res_valid && !res.ready;
    res_found_next = res_found;
    res_pops_next  = res_pops;
    res_ovf_next   = res_ovf;
    res_state_next = res_state;
    g_we    = 1'b0;
    g_waddr = cmd_addr;
    g_wdata = cmd.cell_kind;
    g_raddr = cmd_addr;
    s_we    = 1'b0;
    s_waddr = level[SAW-1:0];
    s_wdata = {nb_r[RW-1:0], nb_c[CW-1:0]};
    s_raddr = level_m1[SAW-1:0];
    case (state)
      S_CLEAR: begin
        g_we          = 1'b1;
        g_waddr       = clr_addr;
        g_wdata       = CELL_OPEN;
        clr_addr_next = clr_addr + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          res_found_next = 1'b0;
          res_pops_next  = '0;
          res_ovf_next   = 1'b0;
          res_state_next = CELL_OPEN;
          case (mode_t'(cmd.mode))
            MODE_WRITE: begin
              g_we           = cmd_on_grid;
              res_valid_next = 1'b1;
            end
            MODE_SEARCH: begin
              pops_next = '0;
              if (start_on_grid) begin
                s_we       = 1'b1;
                s_waddr    = '0;
                s_wdata    = {start_r32[RW-1:0], start_c32[CW-1:0]};
                level_next = LVW'(1);
              end else begin
                level_next     = '0;
                res_valid_next = 1'b1;
              end
            end
            MODE_READ: ;
            default: res_valid_next = 1'b1;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_valid_next = 1'b1;
        res_state_next = rd_on_grid ? g_rdata : CELL_WALL;
      end
      S_POP: begin
        if (level == '0) begin
          res_valid_next = 1'b1;
          res_pops_next  = pops;
        end else begin
          level_next = level_m1;
          if (pops != POP_MAX) pops_next = pops + 1'b1;
        end
      end
      S_FETCH: begin
        cur_r_next = s_rdata[PW-1:CW];
        cur_c_next = s_rdata[CW-1:0];
        g_raddr    = GAW'(32'(s_rdata[PW-1:CW]) * GRID_COLS + 32'(s_rdata[CW-1:0]));
      end
      S_CHECK: begin
        nb_next = 2'd0;
        case (cell_t'(g_rdata))
          CELL_GOAL: begin
            res_valid_next = 1'b1;
            res_found_next = 1'b1;
            res_pops_next  = pops;
          end
          CELL_OPEN: begin
            g_we    = 1'b1;
            g_waddr = GAW'(32'(cur_r) * GRID_COLS + 32'(cur_c));
            g_wdata = CELL_SEEN;
          end
          default: ;
        endcase
      end
      S_PUSH: begin
        nb_next = nb + 1'b1;
        if (nb_ok) begin
          if (stack_full) begin
            res_valid_next = 1'b1;
            res_ovf_next   = 1'b1;
            res_pops_next  = pops;
          end else begin
            s_we       = 1'b1;
            level_next = level + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      level     <= '0;
      res_valid <= 1'b0;
      start_row <= COORD_W'(1);
      start_col <= COORD_W'(1);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      level     <= level_next;
      res_valid <= res_valid_next;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_ROW: start_row <= cfg_data;
          REG_START_COL: start_col <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pops      <= pops_next;
    cur_r     <= cur_r_next;
    cur_c     <= cur_c_next;
    nb        <= nb_next;
    res_found <= res_found_next;
    res_pops  <= res_pops_next;
    res_ovf   <= res_ovf_next;
    res_state <= res_state_next;
    if (accept) rd_on_grid <= cmd_on_grid;
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    32'(level) <= STACK_DEPTH)
    else $error("stack level beyond depth");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!cmd.ready && !res.valid))
    else $error("activity during grid clearing");

  a_found_ovf: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.found && res.overflow))
    else $error("result both found and overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && nb_ok && !stack_full) |=> (level == $past(level) + 1'b1))
    else $error("push did not raise stack level");

endmodule
